// ===== sv/five_point_stencil_average_unit_assert.svh =====
// Assertion macros shared by the stencil average unit.
`ifndef FIVE_POINT_STENCIL_AVERAGE_UNIT_ASSERT_SVH
`define FIVE_POINT_STENCIL_AVERAGE_UNIT_ASSERT_SVH
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FSPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/fspa_pkg.sv =====
// Shared constants, codes and types of the stencil average unit.
package fspa_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int SUM_BITS       = SAMPLE_BITS + 3;
  // floor(s / 5) == (s * ceil(2^30 / 5)) >> 30 for every s below 2^30
  localparam int DIV5_MUL_BITS  = 28;
  localparam logic [DIV5_MUL_BITS-1:0] DIV5_MUL = 28'd214748365;
  localparam int DIV5_SHIFT     = 30;
  localparam int PROD_BITS      = SUM_BITS + DIV5_MUL_BITS;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int LW_BITS        = 10;
  localparam int FH_BITS        = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_IDX_BITS   = 1;
  localparam int COL_OUT_BITS   = 9;
  localparam int ROW_OUT_BITS   = 12;

  localparam int LINE_WIDTH_RST   = 512;
  localparam int FRAME_HEIGHT_RST = 512;

  localparam int FIFO_DEPTH     = 4;

  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_DRAIN   = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]  mean_value;
    logic [COL_OUT_BITS-1:0] out_col;
    logic [ROW_OUT_BITS-1:0] out_row;
    logic                    frame_end;
  } result_t;

endpackage

// ===== sv/five_point_stencil_average_unit.sv =====
// Five-point cross stencil mean filter over a raster-order grid stream.
//
// Input channel (in_valid_i/in_ready_o): one item per grid point in raster order,
// mode_i = 0 with sample_i for grid rows, then one row of line-width drain items
// (mode_i = 1) that stand for the zero row below and flush the last grid row.
// An item of the wrong kind for the current row is taken and dropped.
// Output channel (out_valid_o/out_ready_i): point (x,y) leaves after item (x,y+1)
// is taken; frame_end_o marks the last point of the frame. The first input row
// yields no results.
// Throughput: one item per clock while in_ready_o is high, set by one access
// per cycle on each row-store port. Results pass the stage B and C registers.
// A 4-entry result queue sits behind the 3-stage pipeline; in_ready_o drops only
// when the queue plus in-flight results could fill it, so a stalled receiver
// stops intake after at most 4 pending results, and nothing is lost.
// Configuration (cfg_we_i/cfg_idx_i/cfg_data_i): write only while idle; any write
// restarts the frame. Widths and heights are clamped to 1..MAX_WIDTH/MAX_HEIGHT.
// Reset: line width and frame height 512, counters at the frame start, queue
// empty. Row-store contents are left undefined and are never cleared.
module five_point_stencil_average_unit #(
  parameter int MAX_WIDTH  = fspa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fspa_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic [fspa_pkg::SAMPLE_BITS-1:0]   sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fspa_pkg::SAMPLE_BITS-1:0]   mean_value_o,
  output logic [fspa_pkg::COL_OUT_BITS-1:0]  out_col_o,
  output logic [fspa_pkg::ROW_OUT_BITS-1:0]  out_row_o,
  output logic                               frame_end_o,
  input  logic                               cfg_we_i,
  input  logic [fspa_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [fspa_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import fspa_pkg::*;

  `include "five_point_stencil_average_unit_assert.svh"

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);
  localparam int OCCW = CNTW + 2;

  function automatic logic [EW-1:0] clamp_w(logic [LW_BITS-1:0] v);
    logic [EW-1:0] r;
    if (v == '0) begin
      r = EW'(1);
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      r = EW'(MAX_WIDTH);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

  function automatic logic [RW-1:0] clamp_h(logic [FH_BITS-1:0] v);
    logic [RW-1:0] r;
    if (v == '0) begin
      r = RW'(1);
    end else if (32'(v) > 32'(MAX_HEIGHT)) begin
      r = RW'(MAX_HEIGHT);
    end else begin
      r = RW'(v);
    end
    return r;
  endfunction

  // Frame control
  logic [EW-1:0]          ew_q;
  logic [RW-1:0]          eh_q;
  logic [CW-1:0]          col_q;
  logic [RW-1:0]          row_q;
  logic [SAMPLE_BITS-1:0] left_q;
  logic                   fwd_q;
  logic [SAMPLE_BITS-1:0] fwd_data_q;

  logic                   drain_row, last_col, kind_ok, accept, step, emit;
  logic [SAMPLE_BITS-1:0] new_rd, old_rd;
  logic [SAMPLE_BITS-1:0] center_a, left_a, down_a;
  logic [CW-1:0]          next_addr;

  // Stage B: operands wait for the right and up reads
  logic                    b_vld_q;
  logic [SAMPLE_BITS-1:0]  b_left_q, b_center_q, b_down_q;
  logic                    b_up_ok_q, b_right_ok_q;
  logic [COL_OUT_BITS-1:0] b_col_q;
  logic [ROW_OUT_BITS-1:0] b_row_q;
  logic                    b_fe_q;
  logic [SAMPLE_BITS-1:0]  up_b, right_b;
  logic [SUM_BITS-1:0]     sum_b;

  // Stage C: divide by five
  logic                    c_vld_q;
  logic [SUM_BITS-1:0]     c_sum_q;
  logic [COL_OUT_BITS-1:0] c_col_q;
  logic [ROW_OUT_BITS-1:0] c_row_q;
  logic                    c_fe_q;
  logic [PROD_BITS-1:0]    prod_c;
  result_t                 res_c, res_out;

  logic [CNTW-1:0]         fifo_cnt;
  logic [OCCW-1:0]         occ;

  assign drain_row = (row_q == eh_q);
  assign last_col  = ((EW'(col_q) + EW'(1)) == ew_q);
  assign kind_ok   = ((mode_i == MODE_DRAIN) == drain_row);
  assign accept    = in_valid_i && in_ready_o;
  assign step      = accept && kind_ok;
  assign emit      = (row_q != '0);

  // The newer-store read of the previous step is this step's center.
  assign center_a  = fwd_q ? fwd_data_q : new_rd;
  assign left_a    = (col_q == '0) ? '0 : left_q;
  assign down_a    = drain_row ? '0 : sample_i;
  assign next_addr = last_col ? '0 : col_q + CW'(1);

  fspa_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_newer_ram (
    .clk_i  (clk_i),
    .we_i   (step),
    .waddr_i(col_q),
    .wdata_i(down_a),
    .re_i   (step),
    .raddr_i(next_addr),
    .rdata_o(new_rd)
  );

  fspa_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_older_ram (
    .clk_i  (clk_i),
    .we_i   (step),
    .waddr_i(col_q),
    .wdata_i(center_a),
    .re_i   (step),
    .raddr_i(col_q),
    .rdata_o(old_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ew_q   <= clamp_w(LW_BITS'(LINE_WIDTH_RST));
      eh_q   <= clamp_h(FH_BITS'(FRAME_HEIGHT_RST));
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
      fwd_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_WIDTH: begin
          ew_q <= clamp_w(cfg_data_i[LW_BITS-1:0]);
        end
        REG_FRAME_HEIGHT: begin
          eh_q <= clamp_h(cfg_data_i[FH_BITS-1:0]);
        end
        default: begin
          ew_q <= ew_q;
        end
      endcase
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
      fwd_q  <= 1'b0;
    end else if (step) begin
      left_q <= center_a;
      // a one-column row reads back the entry it writes: forward the new value
      fwd_q  <= last_col && (col_q == '0);
      if (last_col) begin
        col_q <= '0;
        row_q <= drain_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      fwd_data_q <= down_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      b_vld_q <= step && emit;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_left_q     <= left_a;
    b_center_q   <= center_a;
    b_down_q     <= down_a;
    b_up_ok_q    <= (row_q >= RW'(2)) && (RW > 1);
    b_right_ok_q <= !last_col;
    b_col_q      <= COL_OUT_BITS'(col_q);
    b_row_q      <= ROW_OUT_BITS'(row_q - RW'(1));
    b_fe_q       <= drain_row && last_col;

    c_sum_q      <= sum_b;
    c_col_q      <= b_col_q;
    c_row_q      <= b_row_q;
    c_fe_q       <= b_fe_q;
  end

  assign up_b    = b_up_ok_q ? old_rd : '0;
  assign right_b = b_right_ok_q ? new_rd : '0;
  assign sum_b   = SUM_BITS'(up_b) + SUM_BITS'(b_left_q) + SUM_BITS'(b_center_q)
                 + SUM_BITS'(right_b) + SUM_BITS'(b_down_q);

  assign prod_c  = PROD_BITS'(c_sum_q) * PROD_BITS'(DIV5_MUL);

  always_comb begin
    res_c.mean_value = prod_c[DIV5_SHIFT +: SAMPLE_BITS];
    res_c.out_col    = c_col_q;
    res_c.out_row    = c_row_q;
    res_c.frame_end  = c_fe_q;
  end

  fspa_out_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (c_vld_q),
    .push_data_i(res_c),
    .pop_i      (out_ready_i),
    .data_o     (res_out),
    .valid_o    (out_valid_o),
    .count_o    (fifo_cnt)
  );

  // Reserve a queue slot for every result still in the pipeline.
  assign occ        = OCCW'(fifo_cnt) + OCCW'(b_vld_q) + OCCW'(c_vld_q);
  assign in_ready_o = (occ < OCCW'(FIFO_DEPTH));

  assign mean_value_o = res_out.mean_value;
  assign out_col_o    = res_out.out_col;
  assign out_row_o    = res_out.out_row;
  assign frame_end_o  = res_out.frame_end;

  `FSPA_ASSERT_NOW(a_queue_credit, 1'b1, occ <= OCCW'(FIFO_DEPTH), "result queue overrun")
  `FSPA_ASSERT_NEXT(a_hold_on_stall, in_valid_i && !in_ready_o && !cfg_we_i, $stable(col_q) && $stable(row_q), "position moved without an item")
  `FSPA_ASSERT_NEXT(a_frame_wrap, step && drain_row && last_col, (col_q == '0) && (row_q == '0), "frame did not restart after drain row")

endmodule

// ===== sv/fspa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port, read-first.
module fspa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fspa_out_fifo.sv =====
// Small result queue that decouples the filter pipeline from the receiver.
module fspa_out_fifo #(
  parameter int DEPTH = fspa_pkg::FIFO_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fspa_pkg::result_t push_data_i,
  input  logic              pop_i,
  output fspa_pkg::result_t data_o,
  output logic              valid_o,
  output logic [CNTW-1:0]   count_o
);
  import fspa_pkg::*;

  result_t         mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== tb/tb_five_point_stencil_average_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the five-point stencil average unit.
module tb_five_point_stencil_average_unit;
  import fspa_pkg::*;

  localparam int MAX_COLS       = MAX_WIDTH_DEF;
  localparam int MAX_ROWS       = MAX_HEIGHT_DEF;
  localparam int RANDOM_ITEMS   = 600;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic                   kind;
    logic [SAMPLE_BITS-1:0] pix;
  } grid_item_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     mode_i = MODE_SAMPLE;
  logic [SAMPLE_BITS-1:0]   sample_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [SAMPLE_BITS-1:0]   mean_value_o;
  logic [COL_OUT_BITS-1:0]  out_col_o;
  logic [ROW_OUT_BITS-1:0]  out_row_o;
  logic                     frame_end_o;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = REG_LINE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  five_point_stencil_average_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_value_o (mean_value_o),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .frame_end_o  (frame_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Filter state mirrored in the testbench
  bit [SAMPLE_BITS-1:0] older_line [MAX_COLS];
  bit [SAMPLE_BITS-1:0] newer_line [MAX_COLS];
  bit [SAMPLE_BITS-1:0] win_left, win_center;
  int                   col_pos, row_pos;
  bit [LW_BITS-1:0]     line_width_reg = LW_BITS'(LINE_WIDTH_RST);
  bit [FH_BITS-1:0]     frame_height_reg = FH_BITS'(FRAME_HEIGHT_RST);

  grid_item_t grid_stream[$];
  result_t    pending_means[$];

  int error_count, items_taken, dropped_items, means_checked, frames_seen;
  int grid_settings, queued_grid_items, quiet_cycles;
  int send_wait, send_calm, recv_wait, recv_calm;

  function automatic int active_width();
    if (line_width_reg < 1) return 1;
    if (line_width_reg > MAX_COLS) return MAX_COLS;
    return line_width_reg;
  endfunction

  function automatic int active_height();
    if (frame_height_reg < 1) return 1;
    if (frame_height_reg > MAX_ROWS) return MAX_ROWS;
    return frame_height_reg;
  endfunction

  function automatic void restart_grid();
    win_left   = '0;
    win_center = '0;
    col_pos    = 0;
    row_pos    = 0;
  endfunction

  // Advance the mirrored filter by one item; return 1 when it yields a mean.
  function automatic bit five_point_mean(input logic kind, input logic [SAMPLE_BITS-1:0] pix,
                                         output result_t res);
    int                   w, h, x, r;
    bit                   drain_row;
    bit [SAMPLE_BITS-1:0] below, above, right_nb;
    bit [SUM_BITS-1:0]    total, quot;
    bit                   emit;
    w    = active_width();
    h    = active_height();
    res  = '0;
    emit = 1'b0;
    if (col_pos >= w) col_pos = 0;
    if (row_pos > h) row_pos = 0;
    x = col_pos;
    r = row_pos;
    drain_row = (r == h);
    if ((kind == MODE_DRAIN) != drain_row) begin
      dropped_items++;
      return 1'b0;
    end
    below = drain_row ? '0 : pix;
    if (x == 0) win_left = '0;
    win_center = newer_line[x];
    if (r >= 1) begin
      above    = (r >= 2) ? older_line[x] : '0;
      right_nb = (x + 1 < w) ? newer_line[x + 1] : '0;
      total    = above + win_left + win_center + right_nb + below;
      quot     = total / 5;
      res.mean_value = quot[SAMPLE_BITS-1:0];
      res.out_col    = COL_OUT_BITS'(x);
      res.out_row    = ROW_OUT_BITS'(r - 1);
      res.frame_end  = drain_row && (x + 1 == w);
      emit = 1'b1;
    end
    older_line[x] = win_center;
    newer_line[x] = below;
    win_left      = win_center;
    if (x + 1 < w) begin
      col_pos = x + 1;
    end else begin
      col_pos = 0;
      if (drain_row) restart_grid();
      else row_pos = r + 1;
    end
    return emit;
  endfunction

  function automatic void push_item(input logic kind, input logic [SAMPLE_BITS-1:0] pix);
    grid_item_t it;
    it.kind = kind;
    it.pix  = pix;
    grid_stream.push_back(it);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SAMPLE_BITS'($urandom_range(0, 15));
      3: return ~SAMPLE_BITS'($urandom_range(0, 15));
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // One full frame in raster order plus its drain row, with wrong-kind items mixed in.
  function automatic void queue_frame(input int w, input int h, input int noise_pct);
    int r, x;
    for (r = 0; r <= h; r++) begin
      for (x = 0; x < w; x++) begin
        if ($urandom_range(0, 99) < noise_pct) begin
          if (r < h) push_item(MODE_DRAIN, SAMPLE_BITS'($urandom()));
          else push_item(MODE_SAMPLE, pick_sample());
        end
        if (r < h) push_item(MODE_SAMPLE, pick_sample());
        else push_item(MODE_DRAIN, SAMPLE_BITS'($urandom()));
      end
    end
    queued_grid_items += w * (h + 1);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      error_count++;
    end
  endfunction

  task automatic wait_idle();
    while (grid_stream.size() != 0 || in_valid_i || pending_means.size() != 0)
      @(posedge clk_i);
    // dropped items leave nothing to wait on, so let the pipeline settle
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_BITS'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LINE_WIDTH) line_width_reg = LW_BITS'(val);
    else frame_height_reg = FH_BITS'(val);
    restart_grid();
  endtask

  task automatic set_grid(input int width_val, input int height_val);
    wait_idle();
    write_reg(REG_LINE_WIDTH, width_val);
    write_reg(REG_FRAME_HEIGHT, height_val);
    grid_settings++;
  endtask

  task automatic run_phase(input int width_val, input int height_val, input int frames,
                           input int noise_pct);
    int f;
    set_grid(width_val, height_val);
    for (f = 0; f < frames; f++) queue_frame(active_width(), active_height(), noise_pct);
  endtask

  // Input driver
  always @(posedge clk_i) begin
    grid_item_t nxt;
    result_t    res;
    bit         busy;
    if (rst_ni) begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        busy = 1'b0;
        items_taken++;
        if (five_point_mean(mode_i, sample_i, res)) pending_means.push_back(res);
      end
      if (!busy) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (grid_stream.size() != 0) begin
          nxt = grid_stream.pop_front();
          mode_i   <= nxt.kind;
          sample_i <= nxt.pix;
          busy = 1'b1;
          if (send_calm > 0) send_calm--;
          else if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(15, 60);
          send_wait = (send_calm > 0) ? 0 : $urandom_range(0, 6);
        end
      end
      in_valid_i <= busy;
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_means.size() == 0) begin
          $error("unexpected mean 0x%0h at col %0d row %0d", mean_value_o, out_col_o, out_row_o);
          error_count++;
        end else begin
          want = pending_means.pop_front();
          check_field("mean_value", want.mean_value, mean_value_o);
          check_field("out_col", want.out_col, out_col_o);
          check_field("out_row", want.out_row, out_row_o);
          check_field("frame_end", want.frame_end, frame_end_o);
          means_checked++;
          if (want.frame_end) frames_seen++;
        end
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(0, 29) == 0) recv_calm = $urandom_range(15, 60);
        recv_wait = (recv_calm > 0) ? 0 : $urandom_range(0, 6);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ready_i <= (recv_wait == 0);
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_five_point_stencil_average_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sel, w_reg, h_reg;
    restart_grid();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full-scale samples, zero holes and wrong-kind items on a 3x3 grid
    set_grid(3, 3);
    push_item(MODE_SAMPLE, '1);
    push_item(MODE_SAMPLE, '1);
    push_item(MODE_SAMPLE, '1);
    push_item(MODE_SAMPLE, '1);
    push_item(MODE_DRAIN, '1);
    push_item(MODE_SAMPLE, '0);
    push_item(MODE_SAMPLE, '1);
    push_item(MODE_SAMPLE, '0);
    push_item(MODE_SAMPLE, '1);
    push_item(MODE_SAMPLE, '0);
    push_item(MODE_DRAIN, '0);
    push_item(MODE_SAMPLE, '1);
    push_item(MODE_DRAIN, '1);
    push_item(MODE_DRAIN, '0);

    // Single-point grid: every neighbor is outside, frames back to back
    set_grid(1, 1);
    push_item(MODE_DRAIN, '1);
    push_item(MODE_SAMPLE, '1);
    push_item(MODE_DRAIN, '0);
    push_item(MODE_SAMPLE, SAMPLE_BITS'(1));
    push_item(MODE_SAMPLE, '0);
    push_item(MODE_DRAIN, '1);

    // Register extremes: zero clamps up, an oversized width clamps to the full row
    run_phase(0, 0, 3, 20);
    run_phase(1023, 1, 1, 2);

    // Random grids, mostly small, a few wider ones with short frames
    queued_grid_items = 0;
    while (queued_grid_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        w_reg = $urandom_range(1, 16);
        h_reg = $urandom_range(1, 10);
      end else if (sel < 17) begin
        w_reg = $urandom_range(17, 64);
        h_reg = $urandom_range(1, 4);
      end else if (sel < 19) begin
        w_reg = $urandom_range(0, 2);
        h_reg = $urandom_range(0, 3);
      end else begin
        w_reg = $urandom_range(65, 160);
        h_reg = $urandom_range(0, 1);
      end
      run_phase(w_reg, h_reg, $urandom_range(1, 3), $urandom_range(0, 8));
    end

    wait_idle();
    $display("%0d items taken over %0d grid settings, %0d dropped as the wrong kind",
             items_taken, grid_settings, dropped_items);
    $display("%0d means checked, %0d frames completed", means_checked, frames_seen);
    if (error_count == 0) begin
      $display("tb_five_point_stencil_average_unit passed");
    end else begin
      $display("tb_five_point_stencil_average_unit failed");
    end
    $finish;
  end

endmodule
